// ----- hw/rtl/wbts_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes for the walking-bit test sequencer.
// No dependencies; every other file of the block imports this package.
package wbts_pkg;

  localparam int DATA_W      = 32;  // width of registers and item fields
  localparam int CFG_IDX_W   = 3;   // width of the configuration register index
  localparam int SHIFT_OUT_W = 5;   // width of the reported shift count
  localparam int KIND_W      = 2;

  // Input operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PASS  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FAIL  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_PATTERN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BIT_MASK = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FORCED_BITS      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COMPARE_MASK     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FINAL_VALUE      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TEST_ADDRESS     = 3'd5;

  // Configuration register reset values
  localparam logic [DATA_W-1:0] RST_INITIAL_PATTERN  = 32'h0000_0001;
  localparam logic [DATA_W-1:0] RST_PATTERN_BIT_MASK = 32'hFFFF_FFFF;
  localparam logic [DATA_W-1:0] RST_FORCED_BITS      = 32'h0000_0000;
  localparam logic [DATA_W-1:0] RST_COMPARE_MASK     = 32'hFFFF_FFFF;
  localparam logic [DATA_W-1:0] RST_FINAL_VALUE      = 32'h0000_0000;
  localparam logic [DATA_W-1:0] RST_TEST_ADDRESS     = 32'h0000_0000;

  typedef struct packed {
    logic [DATA_W-1:0] initial_pattern;
    logic [DATA_W-1:0] pattern_bit_mask;
    logic [DATA_W-1:0] forced_bits;
    logic [DATA_W-1:0] compare_mask;
    logic [DATA_W-1:0] final_value;
    logic [DATA_W-1:0] test_address;
  } wbts_cfg_t;

  typedef struct packed {
    logic [KIND_W-1:0]      kind;
    logic [DATA_W-1:0]      write_value;
    logic [DATA_W-1:0]      target_address;
    logic [DATA_W-1:0]      failed_bits;
    logic [DATA_W-1:0]      read_value;
    logic                   phase;
    logic [SHIFT_OUT_W-1:0] shift_count;
  } wbts_result_t;

endpackage

// ----- hw/rtl/wbts_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the walking-bit test sequencer:
// the input item channel and the result channel. Depends on wbts_pkg.
interface wbts_item_if;
  import wbts_pkg::*;
  logic              valid;
  logic              ready;
  logic              op;
  logic [DATA_W-1:0] read_data;

  modport source (output valid, output op, output read_data, input ready);
  modport sink   (input valid, input op, input read_data, output ready);
endinterface

interface wbts_result_if;
  import wbts_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [KIND_W-1:0]      kind;
  logic [DATA_W-1:0]      write_value;
  logic [DATA_W-1:0]      target_address;
  logic [DATA_W-1:0]      failed_bits;
  logic [DATA_W-1:0]      read_value;
  logic                   phase;
  logic [SHIFT_OUT_W-1:0] shift_count;

  modport source (output valid, output kind, output write_value, output target_address,
                  output failed_bits, output read_value, output phase,
                  output shift_count, input ready);
  modport sink   (input valid, input kind, input write_value, input target_address,
                  input failed_bits, input read_value, input phase,
                  input shift_count, output ready);
endinterface

// ----- hw/rtl/walking_bit_test_sequencer.sv -----
`timescale 1ns / 1ps
// Top level of the walking-bit test sequencer: input register, walk core,
// result register and configuration bank. Depends on wbts_pkg, wbts_if,
// wbts_cfg and wbts_core.
//
// Usage:
//   items   - input channel. op = OP_START begins a new test (dropping any
//             running one); op = OP_READ delivers the value read back from
//             the location under test. Read-backs while idle give no result.
//   results - one item per step: a pattern write, the final write with pass,
//             or a failure report with the failing bits.
//   cfg_*   - plain write port for the six registers; write only while the
//             block is idle.
// Path: an accepted item is held in the input register, is evaluated by the
// core on its step and lands in the result register; the step waits while
// the result register holds an item that is not being taken.
// Throughput: one item per cycle while results are taken; the core's compare,
// mask and one-bit rotate is a single step between input and result registers.
// Stall: when the receiver holds ready low, the result register holds its
// item; the input register still fills, then items.ready drops.
// Reset: synchronous, clears the valid bits, the walk state (idle) and the
// configuration registers to their documented values.
module walking_bit_test_sequencer import wbts_pkg::*; #(
  parameter int WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  wbts_item_if.sink            items,
  wbts_result_if.source        results,
  input  logic                 cfg_write_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  wbts_cfg_t         cfg;

  // Input register
  logic              in_valid;
  logic              in_op;
  logic [DATA_W-1:0] in_data;

  // Result register
  logic              out_valid;
  wbts_result_t      out_item;

  logic              step;
  logic              step_valid;
  wbts_result_t      step_result;

  // Advance the held item when the result register is free or being emptied
  assign step        = in_valid && (!out_valid || results.ready);
  assign items.ready = !in_valid || step;

  wbts_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg          (cfg)
  );

  wbts_core #(
    .WIDTH (WIDTH)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .op           (in_op),
    .read_data    (in_data),
    .cfg          (cfg),
    .result_valid (step_valid),
    .result       (step_result)
  );

  // Input register: load on every accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (items.ready) begin
      in_valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      in_op   <= items.op;
      in_data <= items.read_data;
    end
  end

  // Result register: fill on a step with a result, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= step_valid;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && step_valid) begin
      out_item <= step_result;
    end
  end

  assign results.valid          = out_valid;
  assign results.kind           = out_item.kind;
  assign results.write_value    = out_item.write_value;
  assign results.target_address = out_item.target_address;
  assign results.failed_bits    = out_item.failed_bits;
  assign results.read_value     = out_item.read_value;
  assign results.phase          = out_item.phase;
  assign results.shift_count    = out_item.shift_count;

endmodule

// ----- hw/rtl/wbts_cfg.sv -----
`timescale 1ns / 1ps
// Configuration register bank of the walking-bit test sequencer.
// Depends on wbts_pkg.
module wbts_cfg import wbts_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  output wbts_cfg_t            cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.initial_pattern  <= RST_INITIAL_PATTERN;
      cfg.pattern_bit_mask <= RST_PATTERN_BIT_MASK;
      cfg.forced_bits      <= RST_FORCED_BITS;
      cfg.compare_mask     <= RST_COMPARE_MASK;
      cfg.final_value      <= RST_FINAL_VALUE;
      cfg.test_address     <= RST_TEST_ADDRESS;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_INITIAL_PATTERN:  cfg.initial_pattern  <= cfg_data;
        REG_PATTERN_BIT_MASK: cfg.pattern_bit_mask <= cfg_data;
        REG_FORCED_BITS:      cfg.forced_bits      <= cfg_data;
        REG_COMPARE_MASK:     cfg.compare_mask     <= cfg_data;
        REG_FINAL_VALUE:      cfg.final_value      <= cfg_data;
        REG_TEST_ADDRESS:     cfg.test_address     <= cfg_data;
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

endmodule

// ----- hw/rtl/wbts_core.sv -----
`timescale 1ns / 1ps
// Walk state and single-step logic of the walking-bit test sequencer:
// compare, rotate, phase change and result selection. Depends on wbts_pkg.
module wbts_core import wbts_pkg::*; #(
  parameter int WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              op,
  input  logic [DATA_W-1:0] read_data,
  input  wbts_cfg_t         cfg,
  output logic              result_valid,
  output wbts_result_t      result
);

  localparam int EW = (WIDTH > DATA_W) ? WIDTH : DATA_W;
  localparam int SW = $clog2(WIDTH);
  localparam int XW = (SW > SHIFT_OUT_W) ? SW : SHIFT_OUT_W;
  localparam logic [SW-1:0] LAST_SHIFT = SW'(WIDTH - 1);

  // Walk state
  logic             busy;
  logic [WIDTH-1:0] walk;
  logic [WIDTH-1:0] last_write;
  logic             phase_bit;
  logic [SW-1:0]    shift_index;

  logic             busy_next;
  logic [WIDTH-1:0] walk_next;
  logic [WIDTH-1:0] last_write_next;
  logic             phase_next;
  logic [SW-1:0]    shift_next;

  // Configuration and read data brought to WIDTH bits
  logic [EW-1:0]    init_e, pmask_e, forced_e, cmask_e, final_e, rd_e;
  logic [WIDTH-1:0] init_w, pmask_w, forced_w, cmask_w, final_w, rd_w;
  logic [WIDTH-1:0] fail_w, rot_w, wv_w;
  logic [EW-1:0]    fail_e, wv_e, rdo_e, fin_e;
  logic [XW-1:0]    shift_e, cur_shift_e;
  logic             is_start, mismatch, at_last;

  assign init_e   = EW'(cfg.initial_pattern);
  assign pmask_e  = EW'(cfg.pattern_bit_mask);
  assign forced_e = EW'(cfg.forced_bits);
  assign cmask_e  = EW'(cfg.compare_mask);
  assign final_e  = EW'(cfg.final_value);
  assign rd_e     = EW'(read_data);
  assign init_w   = init_e[WIDTH-1:0];
  assign pmask_w  = pmask_e[WIDTH-1:0];
  assign forced_w = forced_e[WIDTH-1:0];
  assign cmask_w  = cmask_e[WIDTH-1:0];
  assign final_w  = final_e[WIDTH-1:0];
  assign rd_w     = rd_e[WIDTH-1:0];

  assign is_start = (op == OP_START);
  assign fail_w   = cmask_w & (last_write ^ rd_w);
  assign mismatch = |fail_w;
  assign rot_w    = {walk[WIDTH-2:0], walk[WIDTH-1]};
  assign at_last  = (shift_index == LAST_SHIFT);

  // Write value of the pattern that comes next
  assign wv_w = (~pmask_w & forced_w) | (pmask_w & walk_next);

  assign fail_e      = EW'(fail_w);
  assign wv_e        = EW'(wv_w);
  assign rdo_e       = EW'(rd_w);
  assign fin_e       = EW'(final_w);
  assign shift_e     = XW'(shift_next);
  assign cur_shift_e = XW'(shift_index);

  // Next walk state
  always_comb begin
    busy_next  = busy;
    walk_next  = walk;
    phase_next = phase_bit;
    shift_next = shift_index;

    if (is_start) begin
      busy_next  = 1'b1;
      walk_next  = init_w;
      phase_next = 1'b0;
      shift_next = '0;
    end else if (busy) begin
      if (!mismatch) begin
        walk_next  = rot_w;
        shift_next = shift_index + SW'(1);
        if (at_last) begin
          shift_next = '0;
          if (!phase_bit) begin
            phase_next = 1'b1;
            walk_next  = ~init_w;
          end else begin
            busy_next = 1'b0;
          end
        end
      end else begin
        busy_next = 1'b0;
      end
    end
  end

  // Result selection
  always_comb begin
    last_write_next = last_write;
    result_valid    = 1'b0;
    result          = '0;

    if (is_start || (busy && !mismatch && !(at_last && phase_bit))) begin
      // Pattern write
      last_write_next       = wv_w;
      result_valid          = 1'b1;
      result.kind           = KIND_WRITE;
      result.write_value    = wv_e[DATA_W-1:0];
      result.target_address = cfg.test_address;
      result.read_value     = is_start ? '0 : rdo_e[DATA_W-1:0];
      result.phase          = phase_next;
      result.shift_count    = shift_e[SHIFT_OUT_W-1:0];
    end else if (busy && !mismatch) begin
      // Both phases done: final write and pass
      result_valid          = 1'b1;
      result.kind           = KIND_PASS;
      result.write_value    = fin_e[DATA_W-1:0];
      result.target_address = cfg.test_address;
      result.read_value     = rdo_e[DATA_W-1:0];
      result.phase          = phase_bit;
      result.shift_count    = cur_shift_e[SHIFT_OUT_W-1:0];
    end else if (busy) begin
      result_valid       = 1'b1;
      result.kind        = KIND_FAIL;
      result.failed_bits = fail_e[DATA_W-1:0];
      result.read_value  = rdo_e[DATA_W-1:0];
      result.phase       = phase_bit;
      result.shift_count = cur_shift_e[SHIFT_OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      walk        <= '0;
      last_write  <= '0;
      phase_bit   <= 1'b0;
      shift_index <= '0;
    end else if (step) begin
      busy        <= busy_next;
      walk        <= walk_next;
      last_write  <= last_write_next;
      phase_bit   <= phase_next;
      shift_index <= shift_next;
    end
  end

endmodule
